/* design/u8hk_pkg.sv */
// Shared types, constants and the fullwidth katakana table for the UTF-8 kana glyph core.
package u8hk_pkg;

    localparam int CP_W    = 21;
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 7;
    localparam int PEND_W  = 2;

    // Code point ranges and glyph anchors
    localparam logic [CP_W-1:0] HW_LOW       = 21'h00FF61;
    localparam logic [CP_W-1:0] HW_HIGH      = 21'h00FF9F;
    localparam logic [CP_W-1:0] FW_LOW       = 21'h0030A1;
    localparam logic [CP_W-1:0] FW_HIGH      = 21'h0030F4;
    localparam logic [CP_W-1:0] FW_LONG_MARK = 21'h0030FC;
    localparam logic [CP_W-1:0] ASCII_MAX    = 21'h00007F;
    localparam logic [7:0]      ASCII_FIRST  = 8'h20;
    localparam logic [7:0]      ASCII_LAST   = 8'h7E;
    localparam logic [7:0]      KANA_FIRST   = 8'hA1;
    localparam logic [7:0]      KANA_LONG    = 8'hB0;
    localparam logic [7:0]      KANA_DV      = 8'hDE;
    localparam logic [7:0]      KANA_SV      = 8'hDF;

    // Font codes
    localparam logic FONT_ASCII = 1'b0;
    localparam logic FONT_KANA  = 1'b1;

    // Voiced mark codes held in the table
    localparam logic [1:0] MK_NO = 2'd0;
    localparam logic [1:0] MK_DV = 2'd1;
    localparam logic [1:0] MK_SV = 2'd2;

    localparam int FW_DEPTH = 84;
    localparam int FW_AW    = $clog2(FW_DEPTH);

    // {mark code, kana byte}; kana byte zero means no glyph
    localparam logic [9:0] FW_TABLE [FW_DEPTH] = '{
        {MK_NO, 8'hA7}, {MK_NO, 8'hB1}, {MK_NO, 8'hA8}, {MK_NO, 8'hB2}, {MK_NO, 8'hA9},
        {MK_NO, 8'hB3}, {MK_NO, 8'hAA}, {MK_NO, 8'hB4}, {MK_NO, 8'hAB}, {MK_NO, 8'hB5},
        {MK_NO, 8'hB6}, {MK_DV, 8'hB6}, {MK_NO, 8'hB7}, {MK_DV, 8'hB7}, {MK_NO, 8'hB8},
        {MK_DV, 8'hB8}, {MK_NO, 8'hB9}, {MK_DV, 8'hB9}, {MK_NO, 8'hBA}, {MK_DV, 8'hBA},
        {MK_NO, 8'hBB}, {MK_DV, 8'hBB}, {MK_NO, 8'hBC}, {MK_DV, 8'hBC}, {MK_NO, 8'hBD},
        {MK_DV, 8'hBD}, {MK_NO, 8'hBE}, {MK_DV, 8'hBE}, {MK_NO, 8'hBF}, {MK_DV, 8'hBF},
        {MK_NO, 8'hC0}, {MK_DV, 8'hC0}, {MK_NO, 8'hC1}, {MK_DV, 8'hC1}, {MK_NO, 8'hAF},
        {MK_NO, 8'hC2}, {MK_DV, 8'hC2}, {MK_NO, 8'hC3}, {MK_DV, 8'hC3}, {MK_NO, 8'hC4},
        {MK_DV, 8'hC4}, {MK_NO, 8'hC5}, {MK_NO, 8'hC6}, {MK_NO, 8'hC7}, {MK_NO, 8'hC8},
        {MK_NO, 8'hC9}, {MK_NO, 8'hCA}, {MK_DV, 8'hCA}, {MK_SV, 8'hCA}, {MK_NO, 8'hCB},
        {MK_DV, 8'hCB}, {MK_SV, 8'hCB}, {MK_NO, 8'hCC}, {MK_DV, 8'hCC}, {MK_SV, 8'hCC},
        {MK_NO, 8'hCD}, {MK_DV, 8'hCD}, {MK_SV, 8'hCD}, {MK_NO, 8'hCE}, {MK_DV, 8'hCE},
        {MK_SV, 8'hCE}, {MK_NO, 8'hCF}, {MK_NO, 8'hD0}, {MK_NO, 8'hD1}, {MK_NO, 8'hD2},
        {MK_NO, 8'hD3}, {MK_NO, 8'hAC}, {MK_NO, 8'hD4}, {MK_NO, 8'hAD}, {MK_NO, 8'hD5},
        {MK_NO, 8'hAE}, {MK_NO, 8'hD6}, {MK_NO, 8'hD7}, {MK_NO, 8'hD8}, {MK_NO, 8'hD9},
        {MK_NO, 8'hDA}, {MK_NO, 8'hDB}, {MK_NO, 8'h00}, {MK_NO, 8'hDC}, {MK_NO, 8'h00},
        {MK_NO, 8'h00}, {MK_NO, 8'hA6}, {MK_NO, 8'hDD}, {MK_DV, 8'hB3}
    };

    // Finished code point from the decoder
    typedef struct packed {
        logic            valid;
        logic [CP_W-1:0] cp;
    } cp_evt_t;

    // One glyph selection
    typedef struct packed {
        logic             font;
        logic [IDX_W-1:0] idx;
        logic             last;
    } glyph_t;

    // Glyphs produced by one byte
    typedef struct packed {
        logic [1:0] count;
        glyph_t     g0;
        glyph_t     g1;
    } glyph_pair_t;

endpackage

/* design/u8hk_decode.sv */
// UTF-8 sequence decoder: pending count, code accumulator and halt flag.
module u8hk_decode (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  logic [u8hk_pkg::BYTE_W-1:0]  text_byte,
    output u8hk_pkg::cp_evt_t            evt
);

    logic [u8hk_pkg::PEND_W-1:0] pend_reg, pend_next;
    logic [u8hk_pkg::CP_W-1:0]   acc_reg, acc_next;
    logic                        halted_reg, halted_next;
    logic [u8hk_pkg::CP_W-1:0]   acc_shift;
    logic [u8hk_pkg::PEND_W-1:0] pend_dec;

    assign acc_shift = {acc_reg[u8hk_pkg::CP_W-7:0], text_byte[5:0]};
    assign pend_dec  = pend_reg - 2'd1;

    // Work out next state and any finished code point
    always_comb
    begin
        pend_next   = pend_reg;
        acc_next    = acc_reg;
        halted_next = halted_reg;
        evt.valid   = 1'b0;
        evt.cp      = acc_shift;
        priority if (text_byte == 8'h00)
        begin
            pend_next   = '0;
            acc_next    = '0;
            halted_next = 1'b0;
        end
        else if (halted_reg)
        begin
            evt.valid = 1'b0;
        end
        else if (pend_reg == '0)
        begin
            priority if (!text_byte[7])
            begin
                evt.valid = 1'b1;
                evt.cp    = {13'd0, text_byte};
            end
            else if (text_byte[7:5] == 3'b110)
            begin
                pend_next = 2'd1;
                acc_next  = {16'd0, text_byte[4:0]};
            end
            else if (text_byte[7:4] == 4'b1110)
            begin
                pend_next = 2'd2;
                acc_next  = {17'd0, text_byte[3:0]};
            end
            else if (text_byte[7:3] == 5'b11110)
            begin
                pend_next = 2'd3;
                acc_next  = {18'd0, text_byte[2:0]};
            end
            else
            begin
                halted_next = 1'b1;
            end
        end
        else if (text_byte[7:6] != 2'b10)
        begin
            halted_next = 1'b1;
            pend_next   = '0;
            acc_next    = '0;
        end
        else
        begin
            pend_next = pend_dec;
            acc_next  = acc_shift;
            if (pend_dec == '0)
            begin
                acc_next = '0;
                if (acc_shift == '0)
                    halted_next = 1'b1;
                else
                    evt.valid = 1'b1;
            end
        end
        if (!fire)
        begin
            pend_next   = pend_reg;
            acc_next    = acc_reg;
            halted_next = halted_reg;
            evt.valid   = 1'b0;
        end
    end

    // Hold decoder state between transactions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg   <= '0;
            acc_reg    <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            pend_reg   <= pend_next;
            acc_reg    <= acc_next;
            halted_reg <= halted_next;
        end
    end

endmodule

/* design/u8hk_map.sv */
// Code point to glyph mapper: ASCII, halfwidth kana and fullwidth katakana.
module u8hk_map (
    input  u8hk_pkg::cp_evt_t    evt,
    output u8hk_pkg::glyph_pair_t pair
);

    logic                          is_ascii, is_print, is_hw, is_fw, is_long;
    logic [u8hk_pkg::CP_W-1:0]     hw_off, fw_off;
    logic [9:0]                    fw_entry;
    logic [7:0]                    kana;
    logic [1:0]                    mark;
    logic [7:0]                    kana_idx, mark_idx;

    assign is_ascii = evt.cp <= u8hk_pkg::ASCII_MAX;
    assign is_print = (evt.cp[7:0] >= u8hk_pkg::ASCII_FIRST)
                   && (evt.cp[7:0] <= u8hk_pkg::ASCII_LAST);
    assign is_hw    = (evt.cp >= u8hk_pkg::HW_LOW) && (evt.cp <= u8hk_pkg::HW_HIGH);
    assign is_fw    = (evt.cp >= u8hk_pkg::FW_LOW) && (evt.cp <= u8hk_pkg::FW_HIGH);
    assign is_long  = evt.cp == u8hk_pkg::FW_LONG_MARK;
    assign hw_off   = evt.cp - u8hk_pkg::HW_LOW;
    assign fw_off   = evt.cp - u8hk_pkg::FW_LOW;
    assign fw_entry = is_fw ? u8hk_pkg::FW_TABLE[fw_off[u8hk_pkg::FW_AW-1:0]] : 10'd0;

    // Pick the kana byte and voiced mark
    always_comb
    begin
        kana = 8'h00;
        mark = u8hk_pkg::MK_NO;
        priority if (is_hw)
            kana = u8hk_pkg::KANA_FIRST + hw_off[7:0];
        else if (is_fw)
        begin
            kana = fw_entry[7:0];
            mark = fw_entry[9:8];
        end
        else if (is_long)
            kana = u8hk_pkg::KANA_LONG;
        else
            kana = 8'h00;
    end

    assign kana_idx = kana - u8hk_pkg::KANA_FIRST;
    assign mark_idx = ((mark == u8hk_pkg::MK_SV) ? u8hk_pkg::KANA_SV : u8hk_pkg::KANA_DV)
                    - u8hk_pkg::KANA_FIRST;

    // Build the glyph pair
    always_comb
    begin
        pair.count   = 2'd0;
        pair.g0.font = u8hk_pkg::FONT_KANA;
        pair.g0.idx  = kana_idx[u8hk_pkg::IDX_W-1:0];
        pair.g0.last = 1'b1;
        pair.g1.font = u8hk_pkg::FONT_KANA;
        pair.g1.idx  = mark_idx[u8hk_pkg::IDX_W-1:0];
        pair.g1.last = 1'b1;
        if (evt.valid)
        begin
            priority if (is_ascii)
            begin
                pair.g0.font = u8hk_pkg::FONT_ASCII;
                pair.g0.idx  = evt.cp[u8hk_pkg::IDX_W-1:0]
                             - u8hk_pkg::ASCII_FIRST[u8hk_pkg::IDX_W-1:0];
                pair.count   = is_print ? 2'd1 : 2'd0;
            end
            else if (kana == 8'h00)
                pair.count = 2'd0;
            else if (mark == u8hk_pkg::MK_NO)
                pair.count = 2'd1;
            else
            begin
                pair.count   = 2'd2;
                pair.g0.last = 1'b0;
            end
        end
    end

endmodule

/* design/u8hk_out_buf.sv */
// Two-slot buffer: takes up to two glyphs at once, gives one per out_ready cycle.
module u8hk_out_buf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  u8hk_pkg::glyph_pair_t pair,
    output logic                  can_push,
    output logic                  out_valid,
    input  logic                  out_ready,
    output u8hk_pkg::glyph_t      head
);

    u8hk_pkg::glyph_t slot0_reg, slot0_next;
    u8hk_pkg::glyph_t slot1_reg, slot1_next;
    logic [1:0]       count_reg, count_next;
    logic             pop;
    logic [1:0]       count_left;

    assign out_valid  = count_reg != 2'd0;
    assign head       = slot0_reg;
    assign pop        = out_valid && out_ready;
    assign count_left = count_reg - {1'b0, pop};
    assign can_push   = count_left == 2'd0;

    // Shift out on pop, load both slots on push
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_left;
        if (pop)
            slot0_next = slot1_reg;
        if (push && can_push)
        begin
            slot0_next = pair.g0;
            slot1_next = pair.g1;
            count_next = pair.count;
        end
    end

    // Advance occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    // Hold glyph payload
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

/* design/utf8_to_halfwidth_kana_glyphs_core.sv */
// Top level of the UTF-8 to halfwidth kana glyph selector.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+---------------------------------------
//   input   | in  | in_valid / in_ready  | text_byte[7:0]
//   output  | out | out_valid / out_ready| font_select, glyph_index[6:0], last_of_run
//
// One byte is taken per cycle into an input register while in_ready is high; decode
// and mapping run in one pass into a registered two-slot result buffer.
// Sustained rate is one byte per cycle while out_ready is high and each byte
// gives at most one glyph; a byte that gives a voiced pair holds up the input
// register while the buffer drains its two slots through the single output port.
// Reset clears the input valid flag, decoder state and buffer occupancy at once.
// A stalled output stops the input once a glyph is buffered and a byte is staged.
module utf8_to_halfwidth_kana_glyphs_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [u8hk_pkg::BYTE_W-1:0]  text_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         font_select,
    output logic [u8hk_pkg::IDX_W-1:0]   glyph_index,
    output logic                         last_of_run
);

    logic                          stage_valid_reg, stage_valid_next;
    logic [u8hk_pkg::BYTE_W-1:0]   stage_byte_reg, stage_byte_next;
    logic                          can_push;
    logic                          stage_fire;
    u8hk_pkg::cp_evt_t             evt;
    u8hk_pkg::glyph_pair_t         pair;
    u8hk_pkg::glyph_t              head;

    assign stage_fire = stage_valid_reg && can_push;
    assign in_ready   = !stage_valid_reg || can_push;

    // Load the input register on each input transaction
    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_byte_next  = stage_byte_reg;
        if (stage_fire)
            stage_valid_next = 1'b0;
        if (in_valid && in_ready)
        begin
            stage_valid_next = 1'b1;
            stage_byte_next  = text_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        stage_byte_reg <= stage_byte_next;
    end

    u8hk_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (stage_fire),
        .text_byte (stage_byte_reg),
        .evt       (evt)
    );

    u8hk_map u_map (
        .evt  (evt),
        .pair (pair)
    );

    u8hk_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (stage_fire),
        .pair      (pair),
        .can_push  (can_push),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign font_select = head.font;
    assign glyph_index = head.idx;
    assign last_of_run = head.last;

`ifndef SYNTHESIS
    // A first glyph of a pair is always followed by its mark
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run && out_ready |=> out_valid && last_of_run)
        else $error("second glyph of a pair missing");

    // Only kana glyphs come in pairs
    a_ascii_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> font_select == u8hk_pkg::FONT_KANA)
        else $error("ASCII glyph not marked last");

    // The mark glyph after a pair start is a voiced mark
    a_mark_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run && out_ready |=>
            glyph_index == 7'h3D || glyph_index == 7'h3E)
        else $error("pair second glyph is not a voiced mark");

    // The input register never drops a byte while the buffer is blocked
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !can_push |=> stage_valid_reg && $stable(stage_byte_reg))
        else $error("input register lost a byte");
`endif

endmodule

/* tb/utf8_to_halfwidth_kana_glyphs_core_tb.sv */
// Self-checking testbench for the UTF-8 to halfwidth kana glyph selector core.
module utf8_to_halfwidth_kana_glyphs_core_tb;

    // One glyph selection as seen on the output port
    typedef struct packed {
        logic                       font;
        logic [u8hk_pkg::IDX_W-1:0] idx;
        logic                       last;
    } glyph_sel_t;

    // One row of the directed table; typed rows carry at most one glyph
    typedef struct packed {
        logic [7:0] b;
        logic       typed;
        logic [1:0] n;
        glyph_sel_t g;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 27;
    localparam int PHASE_ITEMS   = 140;
    localparam int MAX_REPORTS   = 10;

    // Voiced mark codes, short names for the table below
    localparam logic [1:0] MK_NO = u8hk_pkg::MK_NO;
    localparam logic [1:0] MK_DV = u8hk_pkg::MK_DV;
    localparam logic [1:0] MK_SV = u8hk_pkg::MK_SV;

    // {mark code, kana byte} for U+30A1..U+30F4; kana byte zero selects nothing
    localparam logic [9:0] KATAKANA_MAP [84] = '{
        {MK_NO, 8'hA7}, {MK_NO, 8'hB1}, {MK_NO, 8'hA8}, {MK_NO, 8'hB2}, {MK_NO, 8'hA9},
        {MK_NO, 8'hB3}, {MK_NO, 8'hAA}, {MK_NO, 8'hB4}, {MK_NO, 8'hAB}, {MK_NO, 8'hB5},
        {MK_NO, 8'hB6}, {MK_DV, 8'hB6}, {MK_NO, 8'hB7}, {MK_DV, 8'hB7}, {MK_NO, 8'hB8},
        {MK_DV, 8'hB8}, {MK_NO, 8'hB9}, {MK_DV, 8'hB9}, {MK_NO, 8'hBA}, {MK_DV, 8'hBA},
        {MK_NO, 8'hBB}, {MK_DV, 8'hBB}, {MK_NO, 8'hBC}, {MK_DV, 8'hBC}, {MK_NO, 8'hBD},
        {MK_DV, 8'hBD}, {MK_NO, 8'hBE}, {MK_DV, 8'hBE}, {MK_NO, 8'hBF}, {MK_DV, 8'hBF},
        {MK_NO, 8'hC0}, {MK_DV, 8'hC0}, {MK_NO, 8'hC1}, {MK_DV, 8'hC1}, {MK_NO, 8'hAF},
        {MK_NO, 8'hC2}, {MK_DV, 8'hC2}, {MK_NO, 8'hC3}, {MK_DV, 8'hC3}, {MK_NO, 8'hC4},
        {MK_DV, 8'hC4}, {MK_NO, 8'hC5}, {MK_NO, 8'hC6}, {MK_NO, 8'hC7}, {MK_NO, 8'hC8},
        {MK_NO, 8'hC9}, {MK_NO, 8'hCA}, {MK_DV, 8'hCA}, {MK_SV, 8'hCA}, {MK_NO, 8'hCB},
        {MK_DV, 8'hCB}, {MK_SV, 8'hCB}, {MK_NO, 8'hCC}, {MK_DV, 8'hCC}, {MK_SV, 8'hCC},
        {MK_NO, 8'hCD}, {MK_DV, 8'hCD}, {MK_SV, 8'hCD}, {MK_NO, 8'hCE}, {MK_DV, 8'hCE},
        {MK_SV, 8'hCE}, {MK_NO, 8'hCF}, {MK_NO, 8'hD0}, {MK_NO, 8'hD1}, {MK_NO, 8'hD2},
        {MK_NO, 8'hD3}, {MK_NO, 8'hAC}, {MK_NO, 8'hD4}, {MK_NO, 8'hAD}, {MK_NO, 8'hD5},
        {MK_NO, 8'hAE}, {MK_NO, 8'hD6}, {MK_NO, 8'hD7}, {MK_NO, 8'hD8}, {MK_NO, 8'hD9},
        {MK_NO, 8'hDA}, {MK_NO, 8'hDB}, {MK_NO, 8'h00}, {MK_NO, 8'hDC}, {MK_NO, 8'h00},
        {MK_NO, 8'h00}, {MK_NO, 8'hA6}, {MK_NO, 8'hDD}, {MK_DV, 8'hB3}
    };

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [7:0]                 text_byte = 8'h00;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic                       font_select;
    logic [u8hk_pkg::IDX_W-1:0] glyph_index;
    logic                       last_of_run;

    // Decoder state mirrored by the predictor
    logic [1:0]  dec_pending = 2'd0;
    logic [20:0] dec_accum = 21'd0;
    logic        dec_halted = 1'b0;

    glyph_sel_t  glyph_q [$];
    glyph_sel_t  head_glyph;
    stim_row_t   directed_rows [DIRECTED_ROWS];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int bytes_fed = 0;
    int live_bytes = 0;
    int strings_fed = 0;
    int pairs_seen = 0;
    int glyphs_checked = 0;

    utf8_to_halfwidth_kana_glyphs_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .font_select (font_select),
        .glyph_index (glyph_index),
        .last_of_run (last_of_run)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic glyph_sel_t make_glyph(input logic font, input logic [7:0] idx,
                                              input logic last);
        glyph_sel_t r;
        r.font = font;
        r.idx  = idx[u8hk_pkg::IDX_W-1:0];
        r.last = last;
        return r;
    endfunction

    // Map one finished code point to its glyph selections
    function automatic void map_code_point(input logic [20:0] cp, output glyph_sel_t [1:0] g,
                                           output int n);
        logic [20:0] off;
        logic [9:0]  ent;
        logic [7:0]  kana;
        logic [1:0]  mark;
        n    = 0;
        g    = '0;
        kana = 8'h00;
        mark = MK_NO;
        off  = 21'd0;
        if (cp <= u8hk_pkg::ASCII_MAX)
        begin
            if (cp >= 21'(u8hk_pkg::ASCII_FIRST) && cp <= 21'(u8hk_pkg::ASCII_LAST))
            begin
                g[0] = make_glyph(u8hk_pkg::FONT_ASCII, cp[7:0] - u8hk_pkg::ASCII_FIRST, 1'b1);
                n = 1;
            end
            return;
        end
        if (cp >= u8hk_pkg::HW_LOW && cp <= u8hk_pkg::HW_HIGH)
        begin
            off  = cp - u8hk_pkg::HW_LOW;
            kana = u8hk_pkg::KANA_FIRST + off[7:0];
        end
        else if (cp >= u8hk_pkg::FW_LOW && cp <= u8hk_pkg::FW_HIGH)
        begin
            off  = cp - u8hk_pkg::FW_LOW;
            ent  = KATAKANA_MAP[off[6:0]];
            mark = ent[9:8];
            kana = ent[7:0];
        end
        else if (cp == u8hk_pkg::FW_LONG_MARK)
        begin
            kana = u8hk_pkg::KANA_LONG;
        end
        if (kana == 8'h00)
            return;
        if (mark == MK_NO)
        begin
            g[0] = make_glyph(u8hk_pkg::FONT_KANA, kana - u8hk_pkg::KANA_FIRST, 1'b1);
            n = 1;
            return;
        end
        g[0] = make_glyph(u8hk_pkg::FONT_KANA, kana - u8hk_pkg::KANA_FIRST, 1'b0);
        g[1] = make_glyph(u8hk_pkg::FONT_KANA,
                          ((mark == MK_DV) ? u8hk_pkg::KANA_DV : u8hk_pkg::KANA_SV)
                          - u8hk_pkg::KANA_FIRST, 1'b1);
        n = 2;
        pairs_seen++;
    endfunction

    // Advance the decoder by one byte and return the glyphs it produces
    function automatic void decode_byte(input logic [7:0] b, output glyph_sel_t [1:0] g,
                                        output int n);
        logic [20:0] cp;
        n = 0;
        g = '0;
        if (b == 8'h00)
        begin
            dec_pending = 2'd0;
            dec_accum   = 21'd0;
            dec_halted  = 1'b0;
            live_bytes++;
            return;
        end
        if (dec_halted)
            return;
        live_bytes++;
        if (dec_pending == 2'd0)
        begin
            if (b[7] == 1'b0)
            begin
                map_code_point({13'd0, b}, g, n);
            end
            else if (b[7:5] == 3'b110)
            begin
                dec_pending = 2'd1;
                dec_accum   = {16'd0, b[4:0]};
            end
            else if (b[7:4] == 4'b1110)
            begin
                dec_pending = 2'd2;
                dec_accum   = {17'd0, b[3:0]};
            end
            else if (b[7:3] == 5'b11110)
            begin
                dec_pending = 2'd3;
                dec_accum   = {18'd0, b[2:0]};
            end
            else
            begin
                dec_halted = 1'b1;
            end
            return;
        end
        if (b[7:6] != 2'b10)
        begin
            dec_halted  = 1'b1;
            dec_pending = 2'd0;
            dec_accum   = 21'd0;
            return;
        end
        dec_accum   = {dec_accum[14:0], b[5:0]};
        dec_pending = dec_pending - 2'd1;
        if (dec_pending != 2'd0)
            return;
        cp        = dec_accum;
        dec_accum = 21'd0;
        if (cp == 21'd0)
        begin
            dec_halted = 1'b1;
            return;
        end
        map_code_point(cp, g, n);
    endfunction

    function automatic stim_row_t row_predicted(input logic [7:0] b);
        stim_row_t r;
        r   = '0;
        r.b = b;
        return r;
    endfunction

    function automatic stim_row_t row_silent(input logic [7:0] b);
        stim_row_t r;
        r       = '0;
        r.b     = b;
        r.typed = 1'b1;
        return r;
    endfunction

    function automatic stim_row_t row_glyph(input logic [7:0] b, input logic font,
                                            input logic [7:0] idx);
        stim_row_t r;
        r       = row_silent(b);
        r.n     = 2'd1;
        r.g     = make_glyph(font, idx, 1'b1);
        return r;
    endfunction

    // Offer one byte, hold it until the transaction completes, then predict
    task automatic offer_byte(input logic [7:0] b, output glyph_sel_t [1:0] g, output int n);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        text_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_fed++;
        decode_byte(b, g, n);
    endtask

    task automatic feed_byte(input logic [7:0] b);
        glyph_sel_t [1:0] g;
        int n;
        offer_byte(b, g, n);
        for (int k = 0; k < n; k++)
            glyph_q.push_back(g[k]);
    endtask

    // Encode a code point in nb bytes and send the first keep of them
    task automatic feed_encoded(input logic [20:0] cp, input int nb, input int keep);
        logic [3:0][7:0] seq;
        seq = '0;
        unique case (nb)
            1: seq[0] = {1'b0, cp[6:0]};
            2:
            begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int k = 0; k < keep; k++)
            feed_byte(seq[k]);
    endtask

    // Pick a code point weighted toward the mapped ranges, sometimes overlong
    task automatic pick_code_point(output logic [20:0] cp, output int nb);
        int cat;
        cat = $urandom_range(99);
        if (cat < 30)
            cp = 21'($urandom_range(0, 127));
        else if (cat < 50)
            cp = 21'($urandom_range(21'h00FF58, 21'h00FFA8));
        else if (cat < 80)
            cp = 21'($urandom_range(21'h00309C, 21'h003100));
        else if (cat < 90)
            cp = 21'($urandom_range(21'h000080, 21'h00FFFF));
        else
            cp = 21'($urandom_range(21'h010000, 21'h1FFFFF));
        if (cp < 21'h80)
            nb = 1;
        else if (cp < 21'h800)
            nb = 2;
        else if (cp < 21'h10000)
            nb = 3;
        else
            nb = 4;
        if (cp == 21'd0)
            nb = $urandom_range(2, 4);
        else if ($urandom_range(9) == 0)
            nb = $urandom_range(nb, 4);
    endtask

    // Send one string: mostly well-formed code points, some noise, then usually a terminator
    task automatic emit_string();
        int len;
        int pick;
        int nb;
        logic [20:0] cp;
        logic [7:0]  rb;
        len = $urandom_range(1, 10);
        strings_fed++;
        for (int k = 0; k < len; k++)
        begin
            pick = $urandom_range(99);
            pick_code_point(cp, nb);
            if (pick < 86)
            begin
                feed_encoded(cp, nb, nb);
            end
            else if (pick < 89)
            begin
                rb = 8'($urandom_range(1, 255));
                feed_byte(rb);
            end
            else if (pick < 92)
            begin
                rb = 8'($urandom_range(8'h80, 8'hBF));
                feed_byte(rb);
            end
            else if (pick < 94)
            begin
                rb = 8'($urandom_range(8'hF8, 8'hFF));
                feed_byte(rb);
            end
            else if (pick < 97)
            begin
                if (nb < 2)
                    nb = $urandom_range(2, 4);
                feed_encoded(cp, nb, $urandom_range(1, nb - 1));
            end
            else
            begin
                if (nb < 2)
                    nb = $urandom_range(2, 4);
                feed_encoded(cp, nb, $urandom_range(1, nb - 1));
                feed_byte(8'h00);
            end
        end
        if ($urandom_range(9) != 0)
            feed_byte(8'h00);
    endtask

    // Stall the output side at the current idle rate
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // Check every output transaction against the oldest expected glyph
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (glyph_q.size() == 0)
            begin
                log_mismatch($sformatf("unexpected glyph font=%0d idx=%0d last=%0d",
                                       font_select, glyph_index, last_of_run));
            end
            else
            begin
                head_glyph = glyph_q.pop_front();
                glyphs_checked++;
                if (font_select !== head_glyph.font || glyph_index !== head_glyph.idx ||
                    last_of_run !== head_glyph.last)
                begin
                    log_mismatch($sformatf(
                        "glyph %0d: exp font=%0d idx=%0d last=%0d, got font=%0d idx=%0d last=%0d",
                        glyphs_checked, head_glyph.font, head_glyph.idx, head_glyph.last,
                        font_select, glyph_index, last_of_run));
                end
            end
        end
    end

    // Stop a hung run
    initial
    begin
        #400000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int base;
        int n;
        glyph_sel_t [1:0] g;

        directed_rows = '{
            row_glyph(8'h20, u8hk_pkg::FONT_ASCII, 8'd0),   // lowest printable
            row_glyph(8'h7E, u8hk_pkg::FONT_ASCII, 8'd94),  // highest printable
            row_silent(8'h1F),                              // control code
            row_silent(8'hEF), row_silent(8'hBD),
            row_glyph(8'hA1, u8hk_pkg::FONT_KANA, 8'd0),    // U+FF61
            row_silent(8'hEF), row_silent(8'hBE),
            row_glyph(8'h9F, u8hk_pkg::FONT_KANA, 8'd62),   // U+FF9F
            row_predicted(8'hE3), row_predicted(8'h82),
            row_predicted(8'hAC),                           // voiced kana, two glyphs
            row_predicted(8'hE3), row_predicted(8'h83),
            row_predicted(8'h91),                           // semi-voiced kana
            row_silent(8'hC0), row_silent(8'h80),           // overlong zero halts
            row_silent(8'h41),                              // ignored while halted
            row_silent(8'h00),
            row_silent(8'hFF),                              // invalid lead halts
            row_silent(8'h00),
            row_silent(8'hE3), row_silent(8'hC3),           // invalid continuation halts
            row_silent(8'h00),
            row_silent(8'hE3), row_silent(8'h00),           // string end inside a sequence
            row_glyph(8'h41, u8hk_pkg::FONT_ASCII, 8'h21)
        };

        send_idle_pct = 21;
        recv_idle_pct = 56;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; typed rows override the prediction
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            offer_byte(directed_rows[r].b, g, n);
            if (directed_rows[r].typed)
            begin
                if (directed_rows[r].n != 2'd0)
                    glyph_q.push_back(directed_rows[r].g);
            end
            else
            begin
                for (int k = 0; k < n; k++)
                    glyph_q.push_back(g[k]);
            end
        end

        // Random strings under three idle profiles
        base = bytes_fed;
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 56 : 0;
            recv_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 21 : 0;
            while (bytes_fed < base + (ph + 1) * PHASE_ITEMS)
                emit_string();
        end
        in_valid <= 1'b0;

        // Drain the expected glyphs, then watch for strays
        while (glyph_q.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);

        $display("Fed %0d bytes (%0d decoded) in %0d random strings plus a directed table;",
                 bytes_fed, live_bytes, strings_fed);
        $display("checked %0d glyphs, %0d voiced pairs, %0d mismatches.",
                 glyphs_checked, pairs_seen, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
